/* hdl/cpr_pkg.sv */
// Shared types, codes and helpers for the colour palette RAM port unit.
// No dependencies; every other file but cpr_if imports this package.
package cpr_pkg;

  localparam int CprColorRamBytes = 64;
  localparam logic [7:0] CprUnmapped = 8'hFF;
  localparam logic [7:0] CprSpecFixed = 8'h40;
  localparam logic [7:0] CprAutoInc = 8'h80;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cpr_cmd_e;

  typedef enum logic [2:0] {
    SEL_BG_MONO   = 3'd0,
    SEL_OBJ0_MONO = 3'd1,
    SEL_OBJ1_MONO = 3'd2,
    SEL_BG_SPEC   = 3'd3,
    SEL_BG_DATA   = 3'd4,
    SEL_OBJ_SPEC  = 3'd5,
    SEL_OBJ_DATA  = 3'd6
  } cpr_sel_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_FINISH = 1'b1
  } cpr_state_e;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_REG    = 2'd1,
    RES_RAM    = 2'd2,
    RES_COLOUR = 2'd3
  } cpr_res_e;

  typedef struct packed {
    logic start;
    logic load;
  } cpr_ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } cpr_ctrl_sts_t;

  function automatic logic [7:0] cpr_expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

/* hdl/cpr_if.sv */
// Valid/ready channel interfaces for bus access requests and results.
// Depends on nothing; payload fields follow the unit's access format.
interface cpr_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output cmd, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input cmd, input reg_select, input write_data,
                output ready);
endinterface

interface cpr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       color_updated;
  logic       color_is_object;
  logic [4:0] color_entry;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, output read_data, output color_updated,
                  output color_is_object, output color_entry, output red_out,
                  output green_out, output blue_out, input ready);
  modport sink (input valid, input read_data, input color_updated,
                input color_is_object, input color_entry, input red_out,
                input green_out, input blue_out, output ready);
endinterface

/* hdl/cpr_ctrl.sv */
// Access sequencer: accepts one beat, then waits to load the result register.
// Depends on cpr_pkg for state, command and status types.
module cpr_ctrl import cpr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cpr_ctrl_sts_t sts_i,
  output cpr_ctrl_cmd_t cmd_o
);

  cpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.start = 1'b0;
    cmd_o.load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_FINISH: begin
        cmd_o.load = !sts_i.out_stall;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/cpr_datapath.sv */
// Palette registers, colour RAM with per-byte valid bits, colour expansion
// and result register. Depends on cpr_pkg and cpr_rsp_if.
module cpr_datapath import cpr_pkg::*; #(
  parameter int COLOR_RAM_BYTES = CprColorRamBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          cmd_i,
  input  logic [2:0]    reg_select_i,
  input  logic [7:0]    write_data_i,
  input  cpr_ctrl_cmd_t ctrl_i,
  output cpr_ctrl_sts_t sts_o,
  cpr_rsp_if.source     rsp_o
);

  localparam int IdxW = $clog2(COLOR_RAM_BYTES);
  localparam int AddrW = IdxW + 1;
  localparam int Depth = 2 * COLOR_RAM_BYTES;

  logic            en_q;
  logic [7:0]      bg_mono_q, obj0_mono_q, obj1_mono_q;
  logic            bg_inc_q, obj_inc_q;
  logic [IdxW-1:0] bg_idx_q, obj_idx_q;
  logic [Depth-1:0] valid_q;
  logic [7:0]      mem [Depth];
  logic [7:0]      rdata_q;
  logic            hit_q;

  cpr_res_e        kind_q, kind_d;
  logic [7:0]      wbyte_q, rd_reg_q, rd_reg_d;
  logic [IdxW-1:0] idx_q;
  logic            obj_q;

  logic            out_valid_q;
  logic [7:0]      read_data_q, red_q, green_q, blue_q;
  logic            updated_q, is_obj_q;
  logic [4:0]      entry_q;

  logic            wr, data_sel, is_obj, ram_we, ram_re;
  logic [IdxW-1:0] spec_idx;
  logic            spec_inc;
  logic [AddrW-1:0] waddr, raddr;

  assign wr       = (cmd_i == CMD_WRITE);
  assign is_obj   = (reg_select_i == SEL_OBJ_DATA);
  assign data_sel = (reg_select_i == SEL_BG_DATA) || is_obj;
  assign spec_idx = is_obj ? obj_idx_q : bg_idx_q;
  assign spec_inc = is_obj ? obj_inc_q : bg_inc_q;
  assign ram_we   = ctrl_i.start && wr && data_sel && en_q;
  assign ram_re   = ctrl_i.start && data_sel && en_q;
  assign waddr    = {is_obj, spec_idx};
  assign raddr    = {is_obj, wr ? (spec_idx ^ IdxW'(1)) : spec_idx};

  always_comb begin
    rd_reg_d = CprUnmapped;
    unique case (reg_select_i)
      SEL_BG_MONO:   rd_reg_d = bg_mono_q;
      SEL_OBJ0_MONO: rd_reg_d = obj0_mono_q;
      SEL_OBJ1_MONO: rd_reg_d = obj1_mono_q;
      SEL_BG_SPEC: begin
        if (en_q) rd_reg_d = (bg_inc_q ? CprAutoInc : 8'h00) | CprSpecFixed | 8'(bg_idx_q);
      end
      SEL_OBJ_SPEC: begin
        if (en_q) rd_reg_d = (obj_inc_q ? CprAutoInc : 8'h00) | CprSpecFixed | 8'(obj_idx_q);
      end
      default: rd_reg_d = CprUnmapped;
    endcase
  end

  always_comb begin
    if (wr) begin
      kind_d = (data_sel && en_q) ? RES_COLOUR : RES_NONE;
    end else begin
      kind_d = (data_sel && en_q) ? RES_RAM : RES_REG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      bg_mono_q   <= '0;
      obj0_mono_q <= '0;
      obj1_mono_q <= '0;
      bg_inc_q    <= 1'b0;
      obj_inc_q   <= 1'b0;
      bg_idx_q    <= '0;
      obj_idx_q   <= '0;
      valid_q     <= '0;
    end else begin
      if (cfg_we_i) en_q <= cfg_wdata_i;
      if (ram_we) valid_q[waddr] <= 1'b1;
      if (ctrl_i.start && wr) begin
        unique case (reg_select_i)
          SEL_BG_MONO:   bg_mono_q   <= write_data_i;
          SEL_OBJ0_MONO: obj0_mono_q <= write_data_i;
          SEL_OBJ1_MONO: obj1_mono_q <= write_data_i;
          SEL_BG_SPEC: begin
            if (en_q) begin
              bg_inc_q <= write_data_i[7];
              bg_idx_q <= write_data_i[IdxW-1:0];
            end
          end
          SEL_OBJ_SPEC: begin
            if (en_q) begin
              obj_inc_q <= write_data_i[7];
              obj_idx_q <= write_data_i[IdxW-1:0];
            end
          end
          SEL_BG_DATA: begin
            if (en_q && spec_inc) bg_idx_q <= bg_idx_q + IdxW'(1);
          end
          SEL_OBJ_DATA: begin
            if (en_q && spec_inc) obj_idx_q <= obj_idx_q + IdxW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) mem[waddr] <= write_data_i;
    if (ram_re) begin
      rdata_q <= mem[raddr];
      hit_q   <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      kind_q   <= kind_d;
      wbyte_q  <= write_data_i;
      rd_reg_q <= rd_reg_d;
      idx_q    <= spec_idx;
      obj_q    <= is_obj;
    end
  end

  logic [7:0]  ram_byte;
  logic [15:0] colour;

  assign ram_byte = hit_q ? rdata_q : 8'h00;
  assign colour   = idx_q[0] ? {wbyte_q, ram_byte} : {ram_byte, wbyte_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      read_data_q <= 8'h00;
      updated_q   <= 1'b0;
      is_obj_q    <= 1'b0;
      entry_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      case (kind_q)
        RES_REG: read_data_q <= rd_reg_q;
        RES_RAM: read_data_q <= ram_byte;
        RES_COLOUR: begin
          updated_q <= 1'b1;
          is_obj_q  <= obj_q;
          entry_q   <= 5'(idx_q >> 1);
          red_q     <= cpr_expand5(colour[4:0]);
          green_q   <= cpr_expand5(colour[9:5]);
          blue_q    <= cpr_expand5(colour[14:10]);
        end
        default: ;
      endcase
    end
  end

  assign sts_o.out_stall     = out_valid_q && !rsp_o.ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = read_data_q;
  assign rsp_o.color_updated = updated_q;
  assign rsp_o.color_is_object = is_obj_q;
  assign rsp_o.color_entry   = entry_q;
  assign rsp_o.red_out       = red_q;
  assign rsp_o.green_out     = green_q;
  assign rsp_o.blue_out      = blue_q;

  a_start_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> !ctrl_i.start)
    else $error("back-to-back access start");

  a_colour_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.load && kind_q == RES_COLOUR) |-> en_q)
    else $error("colour result while colour access disabled");

  a_colour_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && updated_q) |-> (read_data_q == 8'h00))
    else $error("colour update carries read data");

  a_load_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> !ctrl_i.load || !out_valid_q || rsp_o.ready)
    else $error("result loaded over a stalled beat");

endmodule

/* hdl/color_palette_ram_port_unit.sv */
// Top level of the colour palette RAM port unit.
// Depends on cpr_pkg, cpr_if, cpr_ctrl and cpr_datapath.
//
//   channel   dir   handshake          payload
//   req_i     in    valid/ready        cmd, reg_select, write_data
//   rsp_o     out   valid/ready        read_data, colour update fields
//   cfg       in    cfg_we_i           cfg_wdata_i (colour access enable)
//
// Each access runs through two steps: accept, then load of the result register.
// The colour RAM is one write and one registered read port; a data write
// reads the partner byte of its pair while storing its own.
// Reset clears the control and palette registers and the RAM valid bits at once; no sweep.
// A stalled result holds the unit in its finish state until taken.
module color_palette_ram_port_unit import cpr_pkg::*; #(
  parameter int COLOR_RAM_BYTES = CprColorRamBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  cpr_req_if.sink   req_i,
  cpr_rsp_if.source rsp_o
);

  cpr_ctrl_cmd_t ctrl_cmd;
  cpr_ctrl_sts_t ctrl_sts;
  logic          in_ready;

  assign req_i.ready = in_ready;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  cpr_datapath #(
    .COLOR_RAM_BYTES (COLOR_RAM_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (req_i.cmd),
    .reg_select_i (req_i.reg_select),
    .write_data_i (req_i.write_data),
    .ctrl_i       (ctrl_cmd),
    .sts_o        (ctrl_sts),
    .rsp_o        (rsp_o)
  );

endmodule

/* dv/color_palette_ram_port_unit_tb.sv */
// Testbench for color_palette_ram_port_unit: directed table, then random bus accesses.
// Each accepted result beat is checked against a local palette predictor or a fixed table value.
// Depends on cpr_pkg, cpr_req_if/cpr_rsp_if and the unit itself.
module color_palette_ram_port_unit_tb import cpr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SelUnused = 3'd7;
  localparam int CycleLimit = 200000;
  localparam int RandomPhases = 6;
  localparam int ItemsPerPhase = 140;
  localparam int DirRows = 25;

  typedef struct packed {
    logic [7:0] read_data;
    logic       color_updated;
    logic       color_is_object;
    logic [4:0] color_entry;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } palette_result_t;

  typedef struct packed {
    logic       fixed;
    logic [7:0] rd;
  } known_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_ENABLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    cpr_cmd_e   cmd;
    logic [2:0] sel;
    logic [7:0] data;
    logic       fixed;
    logic [7:0] rd;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  cpr_req_if access_ch ();
  cpr_rsp_if result_ch ();

  color_palette_ram_port_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (access_ch),
    .rsp_o       (result_ch)
  );

  bit [7:0] ram_m [2][CprColorRamBytes];
  bit [7:0] spec_m [2];
  bit [7:0] mono_m [3];
  bit       colour_en_m;

  palette_result_t palette_exp_q[$];
  known_result_t   known_q[$];

  int  errors;
  int  sent;
  int  reads_seen;
  int  updates_seen;
  int  stall_left;
  bit  idle_on;
  dir_row_t dir_rows [DirRows];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("** color_palette_ram_port_unit: FAILED **");
    $finish;
  end

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, 3'b000} | 8'(c >> 2);
  endfunction

  function automatic palette_result_t palette_predict(input logic wr, input logic [2:0] sel,
                                                      input logic [7:0] d);
    palette_result_t r;
    logic            p;
    logic [5:0]      idx;
    logic [15:0]     pair;
    r = '0;
    p = (sel == SEL_OBJ_SPEC) || (sel == SEL_OBJ_DATA);
    idx = spec_m[p][5:0];
    if (wr) begin
      case (sel)
        SEL_BG_MONO, SEL_OBJ0_MONO, SEL_OBJ1_MONO: mono_m[sel[1:0]] = d;
        SEL_BG_SPEC, SEL_OBJ_SPEC: if (colour_en_m) spec_m[p] = d & ~CprSpecFixed;
        SEL_BG_DATA, SEL_OBJ_DATA: begin
          if (colour_en_m) begin
            ram_m[p][idx] = d;
            pair = {ram_m[p][{idx[5:1], 1'b1}], ram_m[p][{idx[5:1], 1'b0}]};
            r.color_updated = 1'b1;
            r.color_is_object = p;
            r.color_entry = idx[5:1];
            r.red_out = widen5(pair[4:0]);
            r.green_out = widen5(pair[9:5]);
            r.blue_out = widen5(pair[14:10]);
            if (spec_m[p][7]) spec_m[p] = CprAutoInc | {2'b00, idx + 6'd1};
          end
        end
        default: ;
      endcase
    end else begin
      r.read_data = CprUnmapped;
      case (sel)
        SEL_BG_MONO, SEL_OBJ0_MONO, SEL_OBJ1_MONO: r.read_data = mono_m[sel[1:0]];
        SEL_BG_SPEC, SEL_OBJ_SPEC: if (colour_en_m) r.read_data = spec_m[p] | CprSpecFixed;
        SEL_BG_DATA, SEL_OBJ_DATA: if (colour_en_m) r.read_data = ram_m[p][idx];
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    palette_result_t exp_r;
    known_result_t   k;
    if (rst_ni) begin
      if (cfg_we_i) colour_en_m = cfg_wdata_i;
      if (result_ch.valid && result_ch.ready) begin
        if (palette_exp_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got rd=%0h upd=%0b", $time,
                   result_ch.read_data, result_ch.color_updated);
        end else begin
          exp_r = palette_exp_q.pop_front();
          check_field("read_data", exp_r.read_data, result_ch.read_data);
          check_field("color_updated", 8'(exp_r.color_updated), 8'(result_ch.color_updated));
          check_field("color_is_object", 8'(exp_r.color_is_object),
                      8'(result_ch.color_is_object));
          check_field("color_entry", 8'(exp_r.color_entry), 8'(result_ch.color_entry));
          check_field("red_out", exp_r.red_out, result_ch.red_out);
          check_field("green_out", exp_r.green_out, result_ch.green_out);
          check_field("blue_out", exp_r.blue_out, result_ch.blue_out);
          if (exp_r.color_updated) updates_seen++;
        end
      end
      if (access_ch.valid && access_ch.ready) begin
        k = known_q.pop_front();
        exp_r = palette_predict(access_ch.cmd, access_ch.reg_select, access_ch.write_data);
        if (k.fixed) begin
          exp_r = '0;
          exp_r.read_data = k.rd;
        end
        if (access_ch.cmd == CMD_READ) reads_seen++;
        palette_exp_q.push_back(exp_r);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(input cpr_cmd_e c, input logic [2:0] s, input logic [7:0] d,
                           input logic fixed = 1'b0, input logic [7:0] rd = 8'h00);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      access_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    known_q.push_back('{fixed: fixed, rd: rd});
    access_ch.valid <= 1'b1;
    access_ch.cmd <= c;
    access_ch.reg_select <= s;
    access_ch.write_data <= d;
    do @(posedge clk_i); while (!access_ch.ready);
    sent++;
  endtask

  task automatic drain();
    access_ch.valid <= 1'b0;
    do @(posedge clk_i); while (palette_exp_q.size() != 0 || known_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int       target;
    int       burst;
    logic     port;
    logic [2:0] sel;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    access_ch.valid = 1'b0;
    access_ch.cmd = CMD_READ;
    access_ch.reg_select = SEL_BG_MONO;
    access_ch.write_data = 8'h00;
    result_ch.ready = 1'b0;
    idle_on = 1'b1;
    dir_rows = '{
      '{ROW_ACCESS, CMD_READ,  SEL_BG_MONO,   8'h00, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_BG_SPEC,   8'h00, 1'b1, 8'hFF},
      '{ROW_ACCESS, CMD_READ,  SEL_OBJ_DATA,  8'h00, 1'b1, 8'hFF},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_SPEC,   8'h80, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_DATA,   8'hFF, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SelUnused,     8'h00, 1'b1, 8'hFF},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_MONO,   8'hFF, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_BG_MONO,   8'h00, 1'b1, 8'hFF},
      '{ROW_ACCESS, CMD_WRITE, SEL_OBJ0_MONO, 8'hA5, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_OBJ1_MONO, 8'h5A, 1'b1, 8'h00},
      '{ROW_ENABLE, CMD_READ,  SEL_BG_MONO,   8'h01, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_BG_SPEC,   8'h00, 1'b1, 8'h40},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_SPEC,   8'hFF, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_BG_SPEC,   8'h00, 1'b1, 8'hFF},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_DATA,   8'hFF, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_BG_SPEC,   8'h00, 1'b1, 8'hC0},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_DATA,   8'h1F, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_BG_DATA,   8'hFF, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_OBJ_SPEC,  8'h00, 1'b1, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_OBJ_DATA,  8'hFF, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SEL_OBJ_DATA,  8'h7F, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_OBJ_DATA,  8'h00, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_READ,  SEL_OBJ1_MONO, 8'h00, 1'b0, 8'h00},
      '{ROW_ACCESS, CMD_WRITE, SelUnused,     8'hFF, 1'b1, 8'h00},
      '{ROW_ENABLE, CMD_READ,  SEL_BG_MONO,   8'h00, 1'b0, 8'h00}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].kind == ROW_ENABLE) begin
        write_enable(dir_rows[i].data[0]);
      end else begin
        send_beat(dir_rows[i].cmd, dir_rows[i].sel, dir_rows[i].data, dir_rows[i].fixed,
                  dir_rows[i].rd);
      end
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == RandomPhases - 1) idle_on = 1'b0;
      write_enable((ph == 0 || ph == RandomPhases - 1) ? 1'b1
                   : (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0));
      target = sent + ItemsPerPhase;
      while (sent < target) begin
        port = $urandom_range(0, 1);
        if ($urandom_range(0, 9) < 6) begin
          send_beat(CMD_WRITE, port ? SEL_OBJ_SPEC : SEL_BG_SPEC,
                    {($urandom_range(0, 3) != 0), 7'($urandom)});
          burst = $urandom_range(1, 10);
          repeat (burst) begin
            sel = port ? SEL_OBJ_DATA : SEL_BG_DATA;
            if ($urandom_range(0, 7) == 0) sel = port ? SEL_OBJ_SPEC : SEL_BG_SPEC;
            send_beat(($urandom_range(0, 3) != 0) ? CMD_WRITE : CMD_READ, sel, 8'($urandom));
          end
        end else begin
          send_beat(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ,
                    3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
    end

    drain();
    $display("Ran %0d bus accesses: %0d reads, %0d colour updates, over %0d random phases",
             sent, reads_seen, updates_seen, RandomPhases);
    $display("with colour access toggled, select 7 and auto-increment wrap exercised.");
    if (errors == 0) begin
      $display("** color_palette_ram_port_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** color_palette_ram_port_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/cpr_pkg.sv
hdl/cpr_if.sv
hdl/cpr_ctrl.sv
hdl/cpr_datapath.sv
hdl/color_palette_ram_port_unit.sv
dv/color_palette_ram_port_unit_tb.sv
